>>> sv/psbd_pkg.sv
package psbd_pkg;

    // Fixed-point defaults and widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int CHARGE_W      = 26;
    localparam int RATE_W        = 17;
    localparam int RATE_FRAC     = 16;
    localparam int LEVEL_W       = 8;
    localparam int PCM_W         = 16;
    localparam int BYTE_W        = 8;

    localparam logic [RATE_W-1:0] CAP_RATE_RESET = RATE_W'(65522);
    localparam logic [RATE_W-1:0] RATE_ONE       = RATE_W'(1) << RATE_FRAC;

    // Packed byte layout
    localparam int ACTIVE_BIT = 7;
    localparam int SIGN_BIT   = 3;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef level_t level_tbl_t [8];

    // round((l+1)*127/8)
    localparam level_tbl_t ACTIVE_LEVEL = '{
        8'sd16, 8'sd32, 8'sd48, 8'sd64, 8'sd79, 8'sd95, 8'sd111, 8'sd127
    };

    // round((3-l)*127/60)
    localparam level_tbl_t NORMAL_LEVEL = '{
        8'sd6, 8'sd4, 8'sd2, 8'sd0, -8'sd2, -8'sd4, -8'sd6, -8'sd8
    };

    // Map a 3-bit level to a signed input level
    function automatic level_t level_of(logic [2:0] lvl, logic active, logic negate);
        level_t v;
        if (active)
        begin
            v = ACTIVE_LEVEL[lvl];
            if (negate)
            begin
                v = -v;
            end
        end
        else
        begin
            v = NORMAL_LEVEL[lvl];
        end
        return v;
    endfunction

endpackage

>>> sv/packed_stereo_byte_decoder.sv
// A request passes the input register, then the result register (out_valid).
// Throughput: one request per cycle while out_stall is low; the filter charge
// loop (one multiply per channel between the input and result registers) sets
// that figure. Reset: rst_n is asynchronous and active low; it clears both
// valid flags and both charges and loads cap_rate with its reset value 65522.
module packed_stereo_byte_decoder #(
    parameter int FRAC_BITS = psbd_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [psbd_pkg::BYTE_W-1:0]      packed_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [psbd_pkg::PCM_W-1:0] left_pcm,
    output logic signed [psbd_pkg::PCM_W-1:0] right_pcm,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [psbd_pkg::RATE_W-1:0]      cfg_data
);
    import psbd_pkg::*;

    localparam int FX_W   = LEVEL_W + FRAC_BITS;
    localparam int OUT_W  = ((FX_W > CHARGE_W) ? FX_W : CHARGE_W) + 1;
    localparam int PROD_W = OUT_W + RATE_W + 1;
    localparam int RND_W  = OUT_W + 1;

    localparam logic signed [PROD_W-1:0] CH_MAX = PROD_W'((2 ** (CHARGE_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] CH_MIN = PROD_W'(-(2 ** (CHARGE_W - 1)));
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (RATE_FRAC - 1);
    localparam logic signed [RND_W-1:0]  OUT_HALF  = RND_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [RND_W-1:0]  Q_MAX = RND_W'(127);
    localparam logic signed [RND_W-1:0]  Q_MIN = RND_W'(-128);

    // Control and payload registers
    logic                      s1_valid_reg;
    logic [BYTE_W-1:0]         s1_byte_reg;
    logic                      out_valid_reg;
    logic signed [PCM_W-1:0]   pcm_reg [2];
    logic signed [PCM_W-1:0]   pcm_next [2];
    logic signed [CHARGE_W-1:0] charge_reg [2];
    logic signed [CHARGE_W-1:0] charge_next [2];
    logic [RATE_W-1:0]         cap_rate_reg;

    logic out_free;
    logic s1_adv;
    logic in_take;
    logic [RATE_W-1:0] rate;
    logic active;
    logic negate;
    level_t level [2];

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Clamp the rate to one
    assign rate = (cap_rate_reg > RATE_ONE) ? RATE_ONE : cap_rate_reg;

    // Decode the packed byte
    assign active   = s1_byte_reg[ACTIVE_BIT];
    assign negate   = s1_byte_reg[SIGN_BIT];
    assign level[0] = level_of(s1_byte_reg[6:4], active, negate);
    assign level[1] = level_of(s1_byte_reg[2:0], active, negate);

    // Filter each channel
    for (genvar ch = 0; ch < 2; ch++)
    begin : g_chan
        logic signed [OUT_W-1:0]  in_fx;
        logic signed [OUT_W-1:0]  diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] prod_rnd;
        logic signed [PROD_W-1:0] prod_rs;
        logic signed [PROD_W-1:0] nc;
        logic signed [RND_W-1:0]  q_rnd;
        logic signed [RND_W-1:0]  q;
        logic signed [LEVEL_W-1:0] q_sat;

        assign in_fx = OUT_W'(level[ch]) <<< FRAC_BITS;
        assign diff  = in_fx - OUT_W'(charge_reg[ch]);

        // Charge update: in - round(diff * rate)
        assign prod     = PROD_W'(diff) * PROD_W'(signed'({1'b0, rate}));
        assign prod_rnd = prod + PROD_HALF - PROD_W'(prod[PROD_W-1]);
        assign prod_rs  = prod_rnd >>> RATE_FRAC;
        assign nc       = PROD_W'(in_fx) - prod_rs;

        always_comb
        begin
            priority if (nc > CH_MAX)
            begin
                charge_next[ch] = CH_MAX[CHARGE_W-1:0];
            end
            else if (nc < CH_MIN)
            begin
                charge_next[ch] = CH_MIN[CHARGE_W-1:0];
            end
            else
            begin
                charge_next[ch] = nc[CHARGE_W-1:0];
            end
        end

        // Round the filtered value and saturate to a byte
        assign q_rnd = RND_W'(diff) + OUT_HALF - RND_W'(diff[OUT_W-1]);
        assign q     = q_rnd >>> FRAC_BITS;

        always_comb
        begin
            priority if (q > Q_MAX)
            begin
                q_sat = Q_MAX[LEVEL_W-1:0];
            end
            else if (q < Q_MIN)
            begin
                q_sat = Q_MIN[LEVEL_W-1:0];
            end
            else
            begin
                q_sat = q[LEVEL_W-1:0];
            end
        end

        assign pcm_next[ch] = {q_sat, 8'h00};
    end

    // Control state, charges and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            charge_reg[0] <= '0;
            charge_reg[1] <= '0;
            cap_rate_reg  <= CAP_RATE_RESET;
        end
        else
        begin
            // Advance the input stage
            if (!s1_valid_reg || out_free)
            begin
                s1_valid_reg <= in_valid;
            end
            // Advance the result stage
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            // Commit the filter charge with the result
            if (s1_adv)
            begin
                charge_reg[0] <= charge_next[0];
                charge_reg[1] <= charge_next[1];
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_rate_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= packed_byte;
        end
        if (s1_adv)
        begin
            pcm_reg[0] <= pcm_next[0];
            pcm_reg[1] <= pcm_next[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign left_pcm  = pcm_reg[0];
    assign right_pcm = pcm_reg[1];

    // Checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input stage");

    a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced request did not reach the result stage");

    a_charge_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> ($stable(charge_reg[0]) && $stable(charge_reg[1])))
        else $error("filter charge changed without a result");

    a_pcm_scaled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (left_pcm[7:0] == 8'h00 && right_pcm[7:0] == 8'h00))
        else $error("pcm sample not a multiple of 256");

endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psbd_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int PHASE_ITEMS  = 210;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam longint CHG_MAX  = (longint'(1) << (CHARGE_W - 1)) - 1;
    localparam longint CHG_MIN  = -(longint'(1) << (CHARGE_W - 1));

    typedef struct packed {
        logic signed [PCM_W-1:0] left;
        logic signed [PCM_W-1:0] right;
    } pcm_pair_t;

    // Filter predictor plus queue of expected PCM pairs
    class pcm_scoreboard;
        logic [RATE_W-1:0] rate;
        longint            charge[2];
        pcm_pair_t         pcm_q[$];
        int                mismatches;

        function new();
            rate       = CAP_RATE_RESET;
            charge[0]  = 0;
            charge[1]  = 0;
            mismatches = 0;
        endfunction

        function void set_rate(logic [RATE_W-1:0] v);
            rate = v;
        endfunction

        function int pending();
            return pcm_q.size();
        endfunction

        // Shift right with rounding half away from zero
        function longint round_away(longint v, int n);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (longint'(1) << (n - 1))) >>> n;
            return (v < 0) ? -m : m;
        endfunction

        function longint input_level(logic [2:0] lvl, logic active, logic negate);
            longint v;
            if (active)
            begin
                case (lvl)
                    3'd0: v = 16;
                    3'd1: v = 32;
                    3'd2: v = 48;
                    3'd3: v = 64;
                    3'd4: v = 79;
                    3'd5: v = 95;
                    3'd6: v = 111;
                    default: v = 127;
                endcase
                if (negate)
                begin
                    v = -v;
                end
            end
            else
            begin
                // Sign bit has no effect in normal mode
                v = 6 - 2 * longint'(lvl);
            end
            return v;
        endfunction

        // One high-pass step on channel ch; returns the PCM sample
        function logic signed [PCM_W-1:0] filter_step(longint lvl, int ch);
            longint in_fx;
            longint diff;
            longint eff_rate;
            longint nc;
            longint q;
            in_fx    = lvl <<< FRAC;
            diff     = in_fx - charge[ch];
            eff_rate = (rate > RATE_ONE) ? longint'(RATE_ONE) : longint'(rate);
            nc       = in_fx - round_away(diff * eff_rate, RATE_FRAC);
            if (nc > CHG_MAX)
            begin
                nc = CHG_MAX;
            end
            if (nc < CHG_MIN)
            begin
                nc = CHG_MIN;
            end
            charge[ch] = nc;
            q = round_away(diff, FRAC);
            if (q > 127)
            begin
                q = 127;
            end
            if (q < -128)
            begin
                q = -128;
            end
            return PCM_W'(q * 256);
        endfunction

        function void note_request(logic [BYTE_W-1:0] b);
            pcm_pair_t p;
            p.left  = filter_step(input_level(b[6:4], b[ACTIVE_BIT], b[SIGN_BIT]), 0);
            p.right = filter_step(input_level(b[2:0], b[ACTIVE_BIT], b[SIGN_BIT]), 1);
            pcm_q.insert(pcm_q.size(), p);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t ns: %s", $time, msg);
            end
        endfunction

        function void check_result(logic signed [PCM_W-1:0] l, logic signed [PCM_W-1:0] r);
            pcm_pair_t p;
            if (pcm_q.size() == 0)
            begin
                report($sformatf("unexpected result left %0d right %0d", l, r));
                return;
            end
            p = pcm_q.pop_front();
            if (l !== p.left)
            begin
                report($sformatf("left_pcm expected %0d actual %0d", p.left, l));
            end
            if (r !== p.right)
            begin
                report($sformatf("right_pcm expected %0d actual %0d", p.right, r));
            end
        endfunction

        function void check_drained();
            while (pcm_q.size() != 0)
            begin
                pcm_pair_t p;
                p = pcm_q.pop_front();
                report($sformatf("missing result left %0d right %0d", p.left, p.right));
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [BYTE_W-1:0]        packed_byte;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [PCM_W-1:0]  left_pcm;
    logic signed [PCM_W-1:0]  right_pcm;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [RATE_W-1:0]        cfg_data;

    pcm_scoreboard sb;
    int  burst_left;
    bit  gaps_on;
    bit  swing_neg;
    int  hold_req;
    int  hold_done;

    packed_stereo_byte_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .packed_byte (packed_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_pcm    (left_pcm),
        .right_pcm   (right_pcm),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(left_pcm, right_pcm);
        end
    end

    // Stall the output on a shifting pattern, with one long hold when requested
    initial
    begin
        int mode;
        int span;
        int hold_left;
        mode      = 0;
        span      = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req != hold_done)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 80);
                end
                span--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= span[0];
                endcase
            end
        end
    end

    // Offer one request and hold it until accepted; gaps fall between bursts
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        in_valid    <= 1'b1;
        packed_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.note_request(b);
    endtask

    // Drop valid and wait until every expected result is back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_rate(v);
    endtask

    // Mix of random bytes, top-four-level swings of alternating sign and normal-mode bytes
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] b;
        case ($urandom_range(0, 3))
            0, 1: b = BYTE_W'($urandom_range(0, 255));
            2:
            begin
                b = {1'b1, 3'($urandom_range(4, 7)), swing_neg, 3'($urandom_range(4, 7))};
                swing_neg = ~swing_neg;
            end
            default: b = {1'b0, 7'($urandom_range(0, 127))};
        endcase
        return b;
    endfunction

    initial
    begin
        logic [RATE_W-1:0] rates[8];
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        packed_byte = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        swing_neg   = 1'b0;
        hold_req    = 0;
        hold_done   = 0;
        sb          = new();

        rates = '{17'd0, 17'd131071, 17'd65536, 17'd1, 17'd65535,
                  17'd65522, 17'd32768, 17'd0};
        rates[7] = RATE_W'($urandom_range(0, 131071));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every level in active positive, active negative and normal mode with sign set
        for (int l = 0; l < 8; l++)
        begin
            send_byte({1'b1, 3'(l), 1'b0, 3'(l)});
            send_byte({1'b1, 3'(l), 1'b1, 3'(7 - l)});
            send_byte({1'b0, 3'(l), 1'b1, 3'(l)});
        end
        send_byte(8'h00);
        wait_idle();

        // Random phases, one per rate setting
        for (int ph = 0; ph < 8; ph++)
        begin
            write_rate(rates[ph]);
            @(posedge clk);
            gaps_on = (ph % 3) != 2;
            if (ph == 2)
            begin
                hold_req++;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_byte(pick_byte());
            end
            wait_idle();
        end

        sb.check_drained();
        if (sb.mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
